>>> src/stm_pkg.sv
// Shared types and constants of the servo timed linear move block.
// Used by every module under src; depends on nothing.
package stm_pkg;

  localparam int ID_W       = 4;
  localparam int ANGLE_W    = 16;
  localparam int DIST_W     = 17;
  localparam int DUR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 8;
  localparam int GRACE_W    = 16;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  localparam int DIV_STEPS  = 17;
  localparam int NUM_W      = 34;
  localparam int DEN_W      = 17;
  localparam int DIV_CNT_W  = 5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic FUNC_START    = 1'b0;
  localparam logic FUNC_FRAME    = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_GRACE     = 1'b1;

  localparam logic [THR_W-1:0]   THR_RESET   = 8'd3;
  localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd25;

  typedef struct packed {
    logic [ANGLE_W-1:0] current;
    logic [ANGLE_W-1:0] start;
    logic [ANGLE_W-1:0] target;
    logic [DIST_W-1:0]  distance;
    logic [DUR_W-1:0]   duration;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  elapsed;
    logic [ANGLE_W-1:0] next;
  } track_entry_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [GRACE_W-1:0] grace;
  } cfg_t;

endpackage

>>> src/stm_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on stm_pkg.
module stm_cfg import stm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  logic [THR_W-1:0]   thr_r;
  logic [GRACE_W-1:0] grace_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      grace_r <= GRACE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_r   <= pwdata[THR_W-1:0];
        REG_GRACE:     grace_r <= pwdata[GRACE_W-1:0];
        default:       thr_r   <= thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, thr_r};
      REG_GRACE:     prdata = {{(CFG_DATA_W-GRACE_W){1'b0}}, grace_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = thr_r;
  assign cfg.grace     = grace_r;

endmodule

>>> src/stm_track_mem.sv
// Per-servo move table: one synchronous memory with a registered read port.
// Entries never written read as zero through a row of valid bits. Depends on stm_pkg.
module stm_track_mem import stm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [IW-1:0] wr_addr,
  input  track_entry_t wr_data,
  input  logic [IW-1:0] rd_addr,
  output track_entry_t rd_data
);

  track_entry_t     mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  track_entry_t     rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/stm_div.sv
// Restoring divider, one quotient bit per cycle, for the move interpolation.
// The quotient is known to fit DIV_STEPS bits. Depends on stm_pkg.
module stm_div import stm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [DIV_STEPS-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_STEPS-1:0] sh_r;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       shifted;

  assign shifted = {rem_r, sh_r[DIV_STEPS-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:DIV_STEPS];
      sh_r  <= num[DIV_STEPS-1:0];
      den_r <= den;
    end else if (busy_r) begin
      if (trial[DEN_W]) begin
        rem_r <= shifted[DEN_W-1:0];
        sh_r  <= {sh_r[DIV_STEPS-2:0], 1'b0};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        sh_r  <= {sh_r[DIV_STEPS-2:0], 1'b1};
      end
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

>>> src/servo_timed_linear_move_top.sv
// Servo timed linear move block: top level with the sequencing state machine.
// Depends on stm_pkg, stm_cfg, stm_track_mem and stm_div.
//
// Usage: each input word carries one command for one servo. tuser selects a
// start of a move (0) or a frame step (1); tdata holds the servo index,
// target angle, duration, measured angle and the current millisecond time.
// Every input word produces exactly one output word with the servo index, its
// commanded angle and the moving, updated, finished and any-moving flags.
// One word is processed at a time. A word that needs an interpolation goes
// through the read, evaluate, multiply, divide and done states, and waits in
// the divide state while the serial divider forms the quotient bit by bit;
// all other words go from evaluate straight to done. The next word is accepted
// in the cycle after the previous result enters the output register.
// If the receiver stalls, the result waits in the output register and the
// block stops after finishing at most one further word.
// After reset the table reads as all zero, no servo is moving, and the
// threshold and grace registers hold 3 and 25. Configuration writes are
// taken in any cycle and should be made while the block is idle.
module servo_timed_linear_move_top import stm_pkg::*; #(
  parameter int SERVOS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: servo_id, target_angle, move_duration, current_angle, now_ms
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: servo_echo, next_angle, moving, updated, finished, any_moving
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DEPTH = (SERVOS < (1 << ID_W)) ? SERVOS : (1 << ID_W);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] SERVOS_W = 8'(SERVOS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_MUL, S_DIV, S_DONE} state_t;

  state_t                   state_r;
  logic                     func_r;
  logic [ID_W-1:0]          id_r;
  logic [ANGLE_W-1:0]       tgt_r;
  logic [DUR_W-1:0]         dur_r;
  logic [ANGLE_W-1:0]       cur_r;
  logic [TIME_W-1:0]        now_r;
  track_entry_t             entry_r;
  logic [2*ANGLE_W-1:0]     prod_r;
  logic                     neg_r;
  logic                     mov_r;
  logic                     upd_r;
  logic                     fin_r;
  logic [DEPTH-1:0]         moving_r;
  logic                     out_tvalid_r;
  logic [OUT_DATA_W-1:0]    out_tdata_r;

  cfg_t                     cfg;
  track_entry_t             rd_entry;
  logic [IW-1:0]            addr;
  logic                     id_ok;
  logic                     moving_cur;
  logic                     slot_free;
  logic                     mem_we;
  logic [DEPTH-1:0]         moving_upd;

  track_entry_t             ev_entry;
  logic                     ev_mov;
  logic                     ev_upd;
  logic                     ev_fin;
  logic                     ev_div;
  logic [DIST_W-1:0]        diff;
  logic [DIST_W-1:0]        abs_diff;
  logic [DIST_W-1:0]        limit;
  logic [DIST_W-1:0]        mag;
  logic [DUR_W-1:0]         e_min;
  logic [2*ANGLE_W-1:0]     prod_nxt;

  logic                     div_start;
  logic                     div_done;
  logic [DIV_STEPS-1:0]     div_quot;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [ANGLE_W-1:0]       step;

  assign addr       = id_r[IW-1:0];
  assign id_ok      = {{(8-ID_W){1'b0}}, id_r} < SERVOS_W;
  assign moving_cur = id_ok && moving_r[addr];
  assign slot_free  = !out_tvalid_r || out_tready;
  assign mem_we     = (state_r == S_DONE) && slot_free && id_ok;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_pready = 1'b1;

  stm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  stm_track_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (addr),
    .wr_data (entry_r),
    .rd_addr (addr),
    .rd_data (rd_entry)
  );

  assign div_start = (state_r == S_MUL);
  assign div_num   = {1'b0, prod_r, 1'b0} + {{(NUM_W-DUR_W){1'b0}}, entry_r.duration};
  assign div_den   = {entry_r.duration, 1'b0};

  stm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign step = neg_r ? (~div_quot[ANGLE_W-1:0] + 1'b1) : div_quot[ANGLE_W-1:0];

  always_comb begin
    diff     = {cur_r[ANGLE_W-1], cur_r} - {rd_entry.target[ANGLE_W-1], rd_entry.target};
    abs_diff = diff[DIST_W-1] ? (~diff + 1'b1) : diff;
    limit    = {1'b0, rd_entry.duration} + {1'b0, cfg.grace};
    mag      = rd_entry.distance[DIST_W-1] ? (~rd_entry.distance + 1'b1) : rd_entry.distance;
    e_min    = (rd_entry.elapsed < {{(TIME_W-DUR_W){1'b0}}, rd_entry.duration}) ?
               rd_entry.elapsed[DUR_W-1:0] : rd_entry.duration;
    prod_nxt = (2*ANGLE_W)'(mag[ANGLE_W-1:0]) * (2*ANGLE_W)'(e_min);
    ev_entry = rd_entry;
    ev_mov   = moving_cur;
    ev_upd   = 1'b0;
    ev_fin   = 1'b0;
    ev_div   = 1'b0;
    if (!id_ok) begin
      ev_mov = 1'b0;
    end else if (func_r == FUNC_START) begin
      ev_entry.start      = rd_entry.current;
      ev_entry.target     = tgt_r;
      ev_entry.distance   = {tgt_r[ANGLE_W-1], tgt_r} -
                            {rd_entry.current[ANGLE_W-1], rd_entry.current};
      ev_entry.duration   = dur_r;
      ev_entry.start_time = now_r;
      ev_entry.elapsed    = '0;
      ev_mov              = 1'b1;
    end else begin
      ev_entry.current = cur_r;
      if (moving_cur) begin
        if ((abs_diff < {{(DIST_W-THR_W){1'b0}}, cfg.threshold}) ||
            (rd_entry.elapsed > {{(TIME_W-DIST_W){1'b0}}, limit})) begin
          ev_mov = 1'b0;
          ev_fin = 1'b1;
        end else begin
          ev_upd           = 1'b1;
          ev_entry.elapsed = now_r - rd_entry.start_time;
          if (rd_entry.duration == '0) begin
            ev_entry.next = rd_entry.start + rd_entry.distance[ANGLE_W-1:0];
          end else begin
            ev_div = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    moving_upd = moving_r;
    if (id_ok) begin
      moving_upd[addr] = mov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      moving_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tuser;
            id_r    <= in_tdata[3:0];
            tgt_r   <= in_tdata[19:4];
            dur_r   <= in_tdata[35:20];
            cur_r   <= in_tdata[51:36];
            now_r   <= in_tdata[83:52];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          entry_r <= ev_entry;
          mov_r   <= ev_mov;
          upd_r   <= ev_upd;
          fin_r   <= ev_fin;
          prod_r  <= prod_nxt;
          neg_r   <= rd_entry.distance[DIST_W-1];
          state_r <= ev_div ? S_MUL : S_DONE;
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            entry_r.next <= entry_r.start + step;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            if (id_ok) begin
              moving_r[addr] <= mov_r;
            end
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {|moving_upd, fin_r, upd_r, mov_r,
                             id_ok ? entry_r.next : {ANGLE_W{1'b0}}, id_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_fin_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[22]) |-> !out_tdata[20])
    else $error("finished word reports servo still moving");

  a_upd_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[21] && out_tdata[22]))
    else $error("updated and finished both set");

  a_any_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[20]) |-> out_tdata[23])
    else $error("moving servo not reflected in any_moving");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while one is in work");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

>>> tb/servo_timed_linear_move_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for servo_timed_linear_move_top: directed and random move traffic,
// checked word by word against a behavioral copy of the servo move table.
// Depends on stm_pkg and the servo_timed_linear_move_top RTL.
module servo_timed_linear_move_top_test import stm_pkg::*; ();

  localparam int NSERVO      = 16;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ID_W-1:0]           servo;
    logic signed [ANGLE_W-1:0] angle;
    logic                      moving;
    logic                      updated;
    logic                      finished;
    logic                      any_busy;
  } servo_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  servo_timed_linear_move_top #(.SERVOS(NSERVO)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite), .cfg_paddr(paddr),
    .cfg_pwdata(pwdata), .cfg_prdata(prdata), .cfg_pready(pready)
  );

  logic [THR_W-1:0]          reach_thr = THR_RESET;
  logic [GRACE_W-1:0]        grace_ms = GRACE_RESET;
  logic signed [ANGLE_W-1:0] pos_meas [NSERVO];
  logic signed [ANGLE_W-1:0] mv_start [NSERVO];
  logic signed [ANGLE_W-1:0] mv_target [NSERVO];
  logic signed [DIST_W-1:0]  mv_dist [NSERVO];
  logic [DUR_W-1:0]          mv_dur [NSERVO];
  logic [TIME_W-1:0]         mv_t0 [NSERVO];
  logic [TIME_W-1:0]         mv_elapsed [NSERVO];
  logic signed [ANGLE_W-1:0] cmd_next [NSERVO];
  logic                      mv_active [NSERVO];

  servo_word_t       pending_cmds [$];
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                steady = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic servo_word_t advance_servo_table(input logic func, input logic [ID_W-1:0] id,
      input logic signed [ANGLE_W-1:0] tgt, input logic [DUR_W-1:0] dur,
      input logic signed [ANGLE_W-1:0] cur, input logic [TIME_W-1:0] now);
    servo_word_t r;
    int diff, ad;
    logic [DUR_W:0] lim;
    logic [TIME_W-1:0] e;
    longint dl, mag, q;
    r = '0;
    if (func == FUNC_START) begin
      mv_start[id] = pos_meas[id];
      mv_target[id] = tgt;
      mv_dist[id] = DIST_W'(int'(tgt) - int'(pos_meas[id]));
      mv_dur[id] = dur;
      mv_t0[id] = now;
      mv_elapsed[id] = '0;
      mv_active[id] = 1'b1;
    end else begin
      pos_meas[id] = cur;
      if (mv_active[id]) begin
        diff = int'(cur) - int'(mv_target[id]);
        ad = (diff < 0) ? -diff : diff;
        lim = {1'b0, mv_dur[id]} + {1'b0, grace_ms};
        if (ad < int'(reach_thr) || mv_elapsed[id] > {{(TIME_W-DUR_W-1){1'b0}}, lim}) begin
          mv_active[id] = 1'b0;
          r.finished = 1'b1;
        end else begin
          if (mv_dur[id] == 0) begin
            cmd_next[id] = ANGLE_W'(int'(mv_start[id]) + int'(mv_dist[id]));
          end else begin
            e = (mv_elapsed[id] < mv_dur[id]) ? mv_elapsed[id] : TIME_W'(mv_dur[id]);
            dl = longint'(mv_dist[id]);
            mag = (dl < 0) ? -dl : dl;
            q = (2 * mag * longint'(e) + longint'(mv_dur[id])) / (2 * longint'(mv_dur[id]));
            cmd_next[id] = ANGLE_W'(longint'(mv_start[id]) + ((dl < 0) ? -q : q));
          end
          r.updated = 1'b1;
          mv_elapsed[id] = now - mv_t0[id];
        end
      end
    end
    r.servo = id;
    r.angle = cmd_next[id];
    r.moving = mv_active[id];
    for (int i = 0; i < NSERVO; i++) begin
      if (mv_active[i]) r.any_busy = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, want %0h", what, cycle_count, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    servo_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        report("unrequested word", 32'(out_tdata), '0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_tdata[3:0] !== want.servo)
          report("servo_echo", 32'(out_tdata[3:0]), 32'(want.servo));
        if (out_tdata[19:4] !== want.angle)
          report("next_angle", 32'(out_tdata[19:4]), 32'(want.angle));
        if (out_tdata[20] !== want.moving)
          report("moving", 32'(out_tdata[20]), 32'(want.moving));
        if (out_tdata[21] !== want.updated)
          report("updated", 32'(out_tdata[21]), 32'(want.updated));
        if (out_tdata[22] !== want.finished)
          report("finished", 32'(out_tdata[22]), 32'(want.finished));
        if (out_tdata[23] !== want.any_busy)
          report("any_moving", 32'(out_tdata[23]), 32'(want.any_busy));
      end
    end
  end

  initial begin : result_sink
    int n;
    wait (rst_n);
    forever begin
      n = draw_gap();
      repeat (n) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(input logic func, input logic [ID_W-1:0] id,
      input logic signed [ANGLE_W-1:0] tgt, input logic [DUR_W-1:0] dur,
      input logic signed [ANGLE_W-1:0] cur, input logic [TIME_W-1:0] now);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tuser <= func;
    in_tdata <= {4'b0, now, cur, dur, tgt, id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_cmds.push_back(advance_servo_table(func, id, tgt, dur, cur, now));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_THRESHOLD) reach_thr = value[THR_W-1:0];
    else grace_ms = value[GRACE_W-1:0];
  endtask

  task automatic run_moves(input int count);
    int base, pick, offs;
    logic [ID_W-1:0] id;
    logic signed [ANGLE_W-1:0] tgt, cur;
    logic [DUR_W-1:0] dur;
    base = $urandom_range(0, NSERVO - 4);
    for (int i = 0; i < count; i++) begin
      id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, NSERVO - 1))
                                       : ID_W'(base + $urandom_range(0, 3));
      clock_ms += $urandom_range(0, 25);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_word(1'($urandom_range(0, 1)), id, 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom);
      end else if (pick < 14 || (!mv_active[id] && pick < 45)) begin
        if ($urandom_range(0, 3) == 0) tgt = 16'($urandom);
        else tgt = 16'(int'(pos_meas[id]) + $urandom_range(0, 4000) - 2000);
        case ($urandom_range(0, 19))
          0: dur = '0;
          1: dur = 16'($urandom);
          default: dur = 16'($urandom_range(1, 300));
        endcase
        send_word(FUNC_START, id, tgt, dur, 16'($urandom), clock_ms);
      end else begin
        offs = $urandom_range(0, 10) - 5;
        case ($urandom_range(0, 3))
          0: cur = 16'(int'(mv_target[id]) + offs);
          1, 2: cur = 16'(int'(cmd_next[id]) + offs);
          default: cur = 16'($urandom);
        endcase
        send_word(FUNC_FRAME, id, 16'($urandom), 16'($urandom), cur, clock_ms);
      end
    end
  endtask

  task automatic test_directed_moves();
    send_word(FUNC_FRAME, 4'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    send_word(FUNC_FRAME, 4'd15, 16'd0, 16'd0, 16'h8000, 32'hFFFF_FFFF);
    send_word(FUNC_START, 4'd15, 16'h7FFF, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(FUNC_FRAME, 4'd15, 16'd0, 16'd0, 16'h8000, 32'd5);
    send_word(FUNC_FRAME, 4'd15, 16'd0, 16'd0, 16'd0, 32'd40);
    send_word(FUNC_FRAME, 4'd15, 16'd0, 16'd0, 16'd0, 32'd41);
    send_word(FUNC_START, 4'd1, 16'h8000, 16'hFFFF, 16'd0, 32'd100);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd100, 32'd200);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd200, 32'd300);
    send_word(FUNC_START, 4'd1, 16'd640, 16'd100, 16'd0, 32'd300);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd200, 32'd350);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd300, 32'd400);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd637, 32'd420);
    send_word(FUNC_FRAME, 4'd1, 16'd0, 16'd0, 16'd638, 32'd430);
    send_word(FUNC_START, 4'd2, 16'd64, 16'd10, 16'd0, 32'd1000);
    send_word(FUNC_FRAME, 4'd2, 16'd0, 16'd0, 16'd0, 32'd1035);
    send_word(FUNC_FRAME, 4'd2, 16'd0, 16'd0, 16'd0, 32'd1036);
    send_word(FUNC_FRAME, 4'd2, 16'd0, 16'd0, 16'd0, 32'd1037);
    send_word(FUNC_START, 4'd3, 16'd1, 16'd2, 16'd0, 32'd0);
    send_word(FUNC_FRAME, 4'd3, 16'd0, 16'd0, -16'sd100, 32'd1);
    send_word(FUNC_FRAME, 4'd3, 16'd0, 16'd0, -16'sd100, 32'd2);
  endtask

  task automatic test_register_settings();
    logic [THR_W-1:0] thr_set [4];
    logic [GRACE_W-1:0] grace_set [4];
    thr_set = '{8'd0, 8'd255, 8'd8, THR_RESET};
    grace_set = '{16'd0, 16'hFFFF, 16'd500, GRACE_RESET};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_THRESHOLD, 32'(thr_set[k]));
      write_reg(REG_GRACE, 32'(grace_set[k]));
      clock_ms = $urandom;
      run_moves(40);
    end
  endtask

  task automatic test_random_traffic();
    clock_ms = 32'hFFFF_FE00;
    run_moves(100);
    steady = 1'b1;
    run_moves(80);
    steady = 1'b0;
    wait_drained();
    clock_ms = $urandom;
    run_moves(130);
    write_reg(REG_THRESHOLD, $urandom_range(0, 40));
    write_reg(REG_GRACE, $urandom_range(0, 200));
    run_moves(90);
  endtask

  initial begin
    for (int i = 0; i < NSERVO; i++) begin
      pos_meas[i] = '0;
      mv_start[i] = '0;
      mv_target[i] = '0;
      mv_dist[i] = '0;
      mv_dur[i] = '0;
      mv_t0[i] = '0;
      mv_elapsed[i] = '0;
      cmd_next[i] = '0;
      mv_active[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_moves();
    test_register_settings();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
